// ===== design/zzvd_pkg.sv =====
// Shared constants for the zigzag varint decoder.
`default_nettype none
package zzvd_pkg;
	localparam int unsigned ValueWidth = 64;
	localparam int unsigned NarrowWidth = 32;
	localparam int unsigned CountWidth = 4;
	localparam int unsigned PaddrWidth = 3;

	localparam logic [CountWidth-1:0] NarrowMaxBytes = 4'd5;
	localparam logic [CountWidth-1:0] WideMaxBytes = 4'd10;

	localparam logic [7:0] PayloadMask = 8'h7F;
	localparam logic [7:0] ContBit = 8'h80;

	localparam logic [1:0] StatusOk = 2'd0;
	localparam logic [1:0] StatusTooLong = 2'd1;
	localparam logic [1:0] StatusTruncated = 2'd2;

	localparam logic RegWideMode = 1'b0;
endpackage
`default_nettype wire

// ===== design/zigzag_varint_decoder.sv =====
// Zigzag varint decoder: input register, per-byte accumulator update and result register.
//
// Bytes of a little-endian base-128 varint stream enter on the in_valid/in_ready
// channel, one item per byte with a flag for the last byte of the buffer. A byte
// with bit 7 clear ends a value, and one result item leaves on the out_valid/out_ready
// channel with the zigzag-decoded value, a status and the byte count. Continuing
// bytes give no result. An over-long value or a buffer that ends inside a value
// gives an error result with a zero value and clears the gathered bits.
// A byte is registered at acceptance in the input register and folded into the
// accumulator as it leaves; the result of a value's last byte goes to the result register.
// One byte is taken every cycle while no result is held back by the receiver; the
// accumulator shift-and-OR loop sets this rate. When the receiver stalls, the result
// register holds and the input register fills, after which in_ready drops until the
// result is taken. Reset clears the pipeline, the accumulator, the byte count and
// wide_mode (narrow 32-bit mode). wide_mode sits at byte address 0 of the APB port.
`default_nettype none
module zigzag_varint_decoder import zzvd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PaddrWidth-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  last_in_buffer,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [ValueWidth-1:0] decoded_value,
	output logic      [1:0]            status,
	output logic      [CountWidth-1:0] bytes_used
);
	logic                  wide_q;
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	logic [ValueWidth-1:0] acc_q;
	logic [CountWidth-1:0] count_q;

	logic                  advance;
	logic                  emit;
	logic [6:0]            shamt;
	logic [ValueWidth-1:0] acc_next;
	logic [CountWidth-1:0] count_next;
	logic [CountWidth-1:0] limit;
	logic [NarrowWidth-1:0] zz32;
	logic [ValueWidth-1:0] zz_value;
	logic [ValueWidth-1:0] res_value;
	logic [1:0]            res_status;
	logic                  cfg_write;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == RegWideMode) ? {31'b0, wide_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b0;
		end else if (cfg_write && paddr[2] == RegWideMode) begin
			wide_q <= pwdata[0];
		end
	end

	assign advance = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_in_buffer;
		end
	end

	always_comb begin
		shamt = {count_q, 3'b000} - {3'b000, count_q};
		acc_next = acc_q;
		if (count_q < WideMaxBytes) begin
			acc_next = acc_q | ({56'b0, byte_s1 & PayloadMask} << shamt[5:0]);
		end
		if (!wide_q) begin
			acc_next[ValueWidth-1:NarrowWidth] = '0;
		end
		count_next = count_q + 4'd1;
		limit = wide_q ? WideMaxBytes : NarrowMaxBytes;

		zz32 = (acc_next[NarrowWidth-1:0] >> 1) ^ {NarrowWidth{acc_next[0]}};
		if (wide_q) begin
			zz_value = (acc_next >> 1) ^ {ValueWidth{acc_next[0]}};
		end else begin
			zz_value = {{(ValueWidth-NarrowWidth){zz32[NarrowWidth-1]}}, zz32};
		end

		emit = 1'b1;
		res_value = '0;
		res_status = StatusOk;
		priority if ((byte_s1 & ContBit) == 8'h00) begin
			res_value = zz_value;
		end else if (count_next >= limit) begin
			res_status = StatusTooLong;
		end else if (last_s1) begin
			res_status = StatusTruncated;
		end else begin
			emit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			count_q <= '0;
		end else if (advance) begin
			if (emit) begin
				acc_q <= '0;
				count_q <= '0;
			end else begin
				acc_q <= acc_next;
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= emit;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			decoded_value <= res_value;
			status <= res_status;
			bytes_used <= count_next;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q < WideMaxBytes)
		else $error("byte count ran past the wide limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> acc_q == '0 && count_q == '0)
		else $error("state not cleared after a result");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != StatusOk |-> decoded_value == '0)
		else $error("error result carries a nonzero value");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bytes_used != 4'd0 && bytes_used <= WideMaxBytes)
		else $error("result byte count out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(count_q))
		else $error("stalled item lost from the input register");
endmodule
`default_nettype wire

// ===== test/zigzag_varint_decoder_tb.sv =====
// Testbench for the zigzag varint decoder: directed and random byte streams checked by a scoreboard.
`timescale 1ns / 100ps

typedef struct packed {
	logic signed [63:0] value;
	logic [1:0]         status;
	logic [3:0]         used;
} varint_decode_t;

class varint_scoreboard;
	bit                 wide;
	logic [63:0]        acc;
	logic [3:0]         count;
	varint_decode_t     expected_decodes[$];
	int                 errors;

	function new();
		wide = 1'b0;
		acc = '0;
		count = '0;
		errors = 0;
	endfunction

	function void set_mode(bit m);
		wide = m;
	endfunction

	function int pending();
		return expected_decodes.size();
	endfunction

	function void take_byte(logic [7:0] b, logic last);
		logic [3:0]     taken;
		logic [31:0]    z32;
		varint_decode_t d;
		taken = count + 4'd1;
		if (count < 4'd10) begin
			acc = acc | ({57'd0, b[6:0]} << (7 * int'(count)));
		end
		if (!wide) begin
			acc[63:32] = '0;
		end
		d.value = '0;
		d.used = taken;
		if (!b[7]) begin
			if (wide) begin
				d.value = (acc >> 1) ^ {64{acc[0]}};
			end else begin
				z32 = (acc[31:0] >> 1) ^ {32{acc[0]}};
				d.value = {{32{z32[31]}}, z32};
			end
			d.status = zzvd_pkg::StatusOk;
		end else if (taken >= (wide ? zzvd_pkg::WideMaxBytes : zzvd_pkg::NarrowMaxBytes)) begin
			d.status = zzvd_pkg::StatusTooLong;
		end else if (last) begin
			d.status = zzvd_pkg::StatusTruncated;
		end else begin
			count = taken;
			return;
		end
		expected_decodes.push_back(d);
		acc = '0;
		count = '0;
	endfunction

	function void check_decode(logic signed [63:0] value, logic [1:0] status, logic [3:0] used);
		varint_decode_t d;
		if (expected_decodes.size() == 0) begin
			$display("%0t: unexpected result: actual value %h status %0d bytes %0d",
				$time, value, status, used);
			errors++;
			return;
		end
		d = expected_decodes.pop_front();
		if (value !== d.value || status !== d.status || used !== d.used) begin
			$display("%0t: mismatch: expected value %h status %0d bytes %0d,",
				$time, d.value, d.status, d.used,
				" actual value %h status %0d bytes %0d", value, status, used);
			errors++;
		end
	endfunction
endclass

module zigzag_varint_decoder_tb;
	import zzvd_pkg::*;

	localparam int unsigned CycleLimit = 300000;
	localparam logic [PaddrWidth-1:0] WideModeAddr = PaddrWidth'(4 * RegWideMode);

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PaddrWidth-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            data_byte = '0;
	logic                  last_in_buffer = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic signed [ValueWidth-1:0] decoded_value;
	logic [1:0]            status;
	logic [CountWidth-1:0] bytes_used;

	varint_scoreboard sb = new();
	int  send_idle_pct = 0;
	int  stall_pct = 0;
	int  items_sent = 0;
	int  cycles = 0;
	int  reg_errors = 0;
	bit  cur_wide = 1'b0;
	bit  hold_request = 1'b0;
	bit  hold_taken = 1'b0;
	int  hold_left = 0;

	zigzag_varint_decoder u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .last_in_buffer(last_in_buffer),
		.out_valid(out_valid), .out_ready(out_ready),
		.decoded_value(decoded_value), .status(status), .bytes_used(bytes_used)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAIL zigzag_varint_decoder");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.take_byte(data_byte, last_in_buffer);
			end
			if (out_valid && out_ready) begin
				sb.check_decode(decoded_value, status, bytes_used);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_request && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic write_mode(input bit m);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= WideModeAddr;
		pwdata <= {$urandom} & ~32'd1 | {31'd0, m};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_mode(m);
		cur_wide = m;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {31'd0, m}) begin
			$display("%0t: register readback: expected %h, actual %h", $time, {31'd0, m}, prdata);
			reg_errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_in_buffer <= last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_random_value();
		int unsigned pick;
		int unsigned lim;
		int unsigned len;
		int unsigned i;
		pick = $urandom_range(99);
		lim = cur_wide ? 10 : 5;
		if (pick < 65) begin
			len = (pick < 45) ? $urandom_range(1, 3) : $urandom_range(1, lim);
			for (i = 0; i < len; i++) begin
				send_byte({i != len - 1, 7'($urandom)},
					(i == len - 1) && ($urandom_range(3) == 0));
			end
		end else if (pick < 77) begin
			len = $urandom_range(1, lim - 1);
			for (i = 0; i < len; i++) begin
				send_byte({1'b1, 7'($urandom)}, i == len - 1);
			end
		end else if (pick < 87) begin
			for (i = 0; i < lim; i++) begin
				send_byte({1'b1, 7'($urandom)}, (i == lim - 1) && $urandom_range(1));
			end
		end else begin
			len = $urandom_range(1, 3);
			for (i = 0; i < len; i++) begin
				send_byte(8'($urandom), $urandom_range(7) == 0);
			end
		end
	endtask

	initial begin
		int p;
		int i;
		int phase_end;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_mode(1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b1);
		for (i = 0; i < 4; i++) send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b0);
		for (i = 0; i < 5; i++) send_byte(8'h80, 1'b0);
		send_byte(8'h81, 1'b1);
		send_byte(8'h81, 1'b0);
		send_byte(8'h82, 1'b0);
		drain();
		write_mode(1'b1);
		send_byte(8'h03, 1'b0);
		for (i = 0; i < 9; i++) send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b1);
		for (i = 0; i < 5; i++) send_byte(8'hC0, 1'b0);
		drain();
		write_mode(1'b0);
		send_byte(8'h85, 1'b0);
		drain();

		for (p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 77; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 77; end
				default: begin send_idle_pct = 26; stall_pct = 26; end
			endcase
			write_mode(p[0] ^ p[2]);
			if (p == 0) hold_request = 1'b1;
			phase_end = items_sent + 56;
			while (items_sent < phase_end) send_random_value();
			drain();
		end

		stall_pct = 0;
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && reg_errors == 0 && sb.pending() == 0) begin
			$display("PASS zigzag_varint_decoder");
		end else begin
			$display("FAIL zigzag_varint_decoder");
		end
		$finish;
	end
endmodule
